[hw/rtl/itl_pkg.sv]
// Package for the interpolated table lookup: item types, codes, sizes.
// No dependencies; used by every module of the block.
`default_nettype none
package itl_pkg;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CountW = AddrW + 1;
  localparam int unsigned DivW = 48;

  localparam logic [1:0] KindClear  = 2'd0;
  localparam logic [1:0] KindAppend = 2'd1;
  localparam logic [1:0] KindQuery  = 2'd2;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  localparam logic [1:0] RegStart = 2'd0;
  localparam logic [1:0] RegEnd   = 2'd1;
  localparam logic [1:0] RegStep  = 2'd2;
  localparam logic [1:0] RegMode  = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] sample_value;
    logic signed [31:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_out;
    logic [1:0]         status;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input item
    logic div_start; // start bin division
    logic div_step;  // one divider iteration
    logic frac_start;
    logic rd;        // floor-correct bin index
    logic mul;       // read samples, latch edge flags and fraction
    logic fin;       // form result
  } itl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
  } itl_sts_t;
endpackage
`default_nettype wire

[hw/rtl/itl_datapath.sv]
// Datapath: sample memory, config registers, radix-2 divider, interpolation.
// Depends on itl_pkg.
`default_nettype none
module itl_datapath import itl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire in_item_t  in_i,
  input  wire itl_cmd_t  cmd_i,
  output itl_sts_t       sts_o,
  output out_item_t      res_o
);
  logic signed [31:0] start_q, end_q;
  logic [30:0] step_q;
  logic mode_q;
  logic [CountW-1:0] count_q;
  logic signed [31:0] small_q;
  logic [31:0] mem [TableDepth];

  logic [1:0] st_q;
  logic signed [31:0] y_q;
  logic       direct_q;   // result known without interpolation
  logic signed [DivW-1:0] d_q;
  logic [DivW-1:0] rem_q, quo_q, dvd_q;
  logic [DivW-1:0] dvs_q;
  logic [5:0] cnt_q;
  logic frac_ph_q;
  logic neg_q;
  logic signed [DivW-1:0] bin_q;
  logic [15:0] frac_q;
  logic signed [31:0] y1_q, y2_q;
  logic signed [49:0] prod_q;
  logic lo_q, hi_q;
  logic [AddrW-1:0] lo_idx, last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0; end_q <= '0; step_q <= 31'd65536; mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStart: start_q <= cfg_data_i;
        RegEnd:   end_q <= cfg_data_i;
        RegStep:  step_q <= cfg_data_i[30:0];
        RegMode:  mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective evaluation point and the div inputs.
  logic signed [32:0] xe;
  logic [31:0] stp;
  logic signed [DivW-1:0] d_c;
  logic [DivW-1:0] dvs_c, rem_sh;
  assign stp = (step_q == '0) ? 32'd1 : {1'b0, step_q};
  assign dvs_c = {{(DivW-33){1'b0}}, stp, 1'b0};
  assign rem_sh = {rem_q[DivW-2:0], dvd_q[DivW-1]};

  always_comb begin
    xe = {in_i.query_x[31], in_i.query_x};
    if (in_i.query_x < start_q) xe = {start_q[31], start_q};
    else if (in_i.query_x > end_q) xe = {end_q[31], end_q};
    d_c = 2 * ($signed({{(DivW-33){xe[32]}}, xe}) - $signed({{(DivW-32){start_q[31]}}, start_q}))
          - $signed({{(DivW-32){1'b0}}, stp});
  end

  assign lo_idx = bin_q[AddrW-1:0];
  assign last_idx = AddrW'(count_q - 1'b1);
  assign sts_o.div_done = (cnt_q == '0);

  // Sample memory: append writes, two registered reads for the interpolation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_i.kind == KindAppend && count_q < CountW'(TableDepth)) begin
      mem[count_q[AddrW-1:0]] <= in_i.sample_value;
    end
    if (cmd_i.mul) begin
      y1_q <= mem[(bin_q < 0) ? '0 : lo_idx];
      y2_q <= mem[(bin_q > $signed({{(DivW-CountW){1'b0}}, count_q}) - 2)
                  ? last_idx : AddrW'(lo_idx + 1'b1)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; small_q <= '0; cnt_q <= '0;
      st_q <= StatusOk; y_q <= '0; direct_q <= 1'b1; d_q <= '0;
      rem_q <= '0; quo_q <= '0; dvd_q <= '0; dvs_q <= '0;
      frac_ph_q <= 1'b0; neg_q <= 1'b0; bin_q <= '0; frac_q <= '0;
      prod_q <= '0; lo_q <= 1'b0; hi_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        st_q <= StatusOk; y_q <= '0; direct_q <= 1'b1;
        case (in_i.kind)
          KindClear: begin count_q <= '0; small_q <= '0; end
          KindAppend: begin
            if (count_q >= CountW'(TableDepth)) st_q <= StatusFull;
            else begin
              if (count_q == '0 || in_i.sample_value < small_q) small_q <= in_i.sample_value;
              count_q <= count_q + 1'b1;
            end
          end
          KindQuery: begin
            if (count_q == '0) st_q <= StatusEmpty;
            else if ((in_i.query_x < start_q || in_i.query_x > end_q) && !mode_q)
              y_q <= small_q;
            else direct_q <= 1'b0;
          end
          default: ;
        endcase
        d_q <= d_c;
      end
      if (cmd_i.div_start) begin
        neg_q <= d_q[DivW-1];
        dvd_q <= d_q[DivW-1] ? DivW'(-d_q) : d_q;
        dvs_q <= dvs_c; rem_q <= '0; quo_q <= '0;
        cnt_q <= 6'(DivW); frac_ph_q <= 1'b0;
      end else if (cmd_i.frac_start) begin
        dvd_q <= {rem_q[DivW-17:0], 16'd0}; rem_q <= '0; quo_q <= '0;
        cnt_q <= 6'(DivW); frac_ph_q <= 1'b1;
      end else if (cmd_i.div_step && cnt_q != '0) begin
        dvd_q <= {dvd_q[DivW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (rem_sh >= dvs_q) begin
          rem_q <= rem_sh - dvs_q; quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh; quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
      end
      if (cmd_i.rd) begin
        // Floor-correct the magnitude quotient for negative dividends.
        if (!frac_ph_q) begin
          if (neg_q) begin
            bin_q <= (rem_q != '0) ? -$signed(quo_q) - 1 : -$signed(quo_q);
            rem_q <= (rem_q != '0) ? dvs_q - rem_q : '0;
          end else bin_q <= $signed(quo_q);
        end
      end
      if (cmd_i.mul) begin
        lo_q <= bin_q < 0;
        hi_q <= bin_q > $signed({{(DivW-CountW){1'b0}}, count_q}) - 2;
        frac_q <= quo_q[15:0];
      end
      if (cmd_i.fin) begin
        prod_q <= (50'(y2_q) - 50'(y1_q)) * $signed({1'b0, frac_q});
      end
    end
  end

  logic signed [31:0] interp;
  always_comb begin
    if (lo_q) interp = y1_q;
    else if (hi_q) interp = y2_q;
    else interp = 32'(y1_q + (prod_q >>> 16));
    res_o.status = st_q;
    res_o.y_out = direct_q ? y_q : interp;
  end
  logic unused;
  assign unused = ^{rem_q[DivW-1:DivW-16]};
endmodule
`default_nettype wire

[hw/rtl/itl_ctrl.sv]
// Controller FSM sequencing divider, memory read and output handshake.
// Depends on itl_pkg.
`default_nettype none
module itl_ctrl import itl_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic empty_i,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  input  wire itl_sts_t sts_i,
  output itl_cmd_t  cmd_o
);
  typedef enum logic [3:0] {
    SIdle, SDiv0, SDiv, SFix, SFrac0, SFrac, SRead, SMul, SOut
  } state_e;
  state_e state_q;

  assign in_ready_o = (state_q == SIdle) || (state_q == SOut && out_ready_i);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.div_start = (state_q == SDiv0);
    cmd_o.div_step = (state_q == SDiv) || (state_q == SFrac);
    cmd_o.rd = (state_q == SFix);
    cmd_o.frac_start = (state_q == SFrac0);
    cmd_o.mul = (state_q == SRead);
    cmd_o.fin = (state_q == SMul);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      case (state_q)
        SIdle, SOut: begin
          if (cmd_o.load) state_q <= (kind_i == KindQuery && !empty_i) ? SDiv0 : SOut;
          else if (state_q == SOut && out_ready_i) state_q <= SIdle;
        end
        SDiv0:  state_q <= SDiv;
        SDiv:   if (sts_i.div_done) state_q <= SFix;
        SFix:   state_q <= SFrac0;
        SFrac0: state_q <= SFrac;
        SFrac:  if (sts_i.div_done) state_q <= SRead;
        SRead:  state_q <= SMul;
        SMul:   state_q <= SOut;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/interpolated_table_lookup.sv]
// Interpolated table lookup on a uniform grid, Q16.16.
// Clear/append/no-op items: result valid the cycle after accept.
// Query: result formed by two 48-step radix-2 division passes (bin index,
// then fraction), a floor fix, memory read and multiply; one item at a time.
// Reset (rst_ni low, async): empty table, grid 0..0, step 1.0, edge mode 0.
`default_nettype none
module interpolated_table_lookup import itl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);
  itl_cmd_t cmd;
  itl_sts_t sts;
  logic empty_q;

  // Track emptiness for the controller's query routing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) empty_q <= 1'b1;
    else if (cmd.load) begin
      if (in_item_i.kind == KindClear) empty_q <= 1'b1;
      else if (in_item_i.kind == KindAppend) empty_q <= 1'b0;
    end
  end

  itl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i(in_item_i.kind),
    .empty_i(empty_q), .out_ready_i, .out_valid_o, .sts_i(sts), .cmd_o(cmd)
  );

  itl_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i(in_item_i),
    .cmd_i(cmd), .sts_o(sts), .res_o(out_item_o)
  );
endmodule
`default_nettype wire
